FILE: hw/rtl/tomq_pkg.sv
// ----------------------------------------------------------------------------
// tomq_pkg
// Shared types, port widths and codes of the timestamp-ordered message queue.
// ----------------------------------------------------------------------------
package tomq_pkg;

   // default storage geometry
   localparam int DEPTH_DEF     = 16;
   localparam int TIME_BITS_DEF = 32;
   localparam int ID_BITS_DEF   = 16;

   // fixed port widths
   localparam int OP_BITS        = 1;
   localparam int MSG_ID_BITS    = 16;
   localparam int MSG_TIME_BITS  = 32;
   localparam int STATUS_BITS    = 2;
   localparam int OCC_BITS       = 5;
   localparam int MAX_SIZE_BITS  = 5;

   localparam logic [MAX_SIZE_BITS-1:0] MAX_SIZE_RESET = 5'd16;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_PUSH = 1'b0;
   localparam logic [OP_BITS-1:0] OP_POP  = 1'b1;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   // per-cycle command broadcast along the chain
   typedef struct packed {
      logic push;   // insert the broadcast entry in order
      logic pop;    // every cell takes its right neighbour's entry
   } tomq_cmd_type;

endpackage

FILE: hw/rtl/tomq_cell.sv
// ----------------------------------------------------------------------------
// tomq_cell
// One slot of the sorted chain: keeps, inserts or shifts its entry each cycle.
// ----------------------------------------------------------------------------
module tomq_cell #(
   parameter int TIME_BITS = tomq_pkg::TIME_BITS_DEF,
   parameter int ID_BITS   = tomq_pkg::ID_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tomq_pkg::tomq_cmd_type cmd,
   input  logic [TIME_BITS-1:0]   new_time,
   input  logic [ID_BITS-1:0]     new_id,
   input  logic                   left_valid,
   input  logic                   left_le,
   input  logic [TIME_BITS-1:0]   left_time,
   input  logic [ID_BITS-1:0]     left_id,
   input  logic                   right_valid,
   input  logic [TIME_BITS-1:0]   right_time,
   input  logic [ID_BITS-1:0]     right_id,
   output logic                   valid,
   output logic                   le,
   output logic [TIME_BITS-1:0]   slot_time,
   output logic [ID_BITS-1:0]     slot_id
);

   logic                 valid_ff, valid_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic                 le_w;

   // entry stays ahead of the new one (equal times keep arrival order)
   assign le_w = valid_ff && (time_ff <= new_time);

   always_comb begin
      valid_in = valid_ff;
      time_in  = time_ff;
      id_in    = id_ff;
      if (cmd.push) begin
         if (le_w) begin
            // keep
         end else if (left_valid && left_le) begin
            valid_in = 1'b1;
            time_in  = new_time;
            id_in    = new_id;
         end else begin
            valid_in = left_valid;
            time_in  = left_time;
            id_in    = left_id;
         end
      end else if (cmd.pop) begin
         valid_in = right_valid;
         time_in  = right_time;
         id_in    = right_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      id_ff   <= id_in;
   end

   assign valid     = valid_ff;
   assign le        = le_w;
   assign slot_time = time_ff;
   assign slot_id   = id_ff;

endmodule

FILE: hw/rtl/timestamp_ordered_message_queue_unit.sv
// ----------------------------------------------------------------------------
// timestamp_ordered_message_queue_unit
// Bounded message queue kept sorted by delivery time in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: a transaction is taken at a rising edge with start high
//    and busy low. req_operation selects push (insert req_message_id ordered
//    by req_deliver_time, after any equal times) or pop (remove the earliest).
//  - Response channel: exactly one response per command, shown for a single
//    cycle with rsp_strobe high, in the cycle after the command. It carries
//    the status (done, full, empty), the popped entry (zero unless a pop
//    succeeded) and the occupancy after the command.
//  - Throughput: one command per cycle while busy is low. Every cell compares
//    its own time with the broadcast one and updates from itself, the new
//    entry or a neighbour in the same cycle, so no command waits for another.
//  - Config channel: csr_max_size sets the capacity limit (values above DEPTH
//    act as DEPTH, zero rejects every push). Write it only while idle.
//  - Reset (synchronous): empties the queue, max_size returns to 16; busy is
//    high for the first cycle after reset.
//  - The receiver cannot stall: responses are never held back.
// ----------------------------------------------------------------------------
module timestamp_ordered_message_queue_unit #(
   parameter int DEPTH     = tomq_pkg::DEPTH_DEF,
   parameter int TIME_BITS = tomq_pkg::TIME_BITS_DEF,
   parameter int ID_BITS   = tomq_pkg::ID_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // command channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic [tomq_pkg::OP_BITS-1:0]         req_operation,
   input  logic [tomq_pkg::MSG_ID_BITS-1:0]     req_message_id,
   input  logic [tomq_pkg::MSG_TIME_BITS-1:0]   req_deliver_time,
   // response channel
   output logic                                 rsp_strobe,
   output logic [tomq_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [tomq_pkg::MSG_ID_BITS-1:0]     rsp_popped_id,
   output logic [tomq_pkg::MSG_TIME_BITS-1:0]   rsp_popped_time,
   output logic [tomq_pkg::OCC_BITS-1:0]        rsp_occupancy,
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tomq_pkg::MAX_SIZE_BITS-1:0]   csr_max_size
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS = (CNT_BITS > tomq_pkg::MAX_SIZE_BITS) ?
                             CNT_BITS : tomq_pkg::MAX_SIZE_BITS;

   // control state
   logic                                busy_ff;
   logic [tomq_pkg::MAX_SIZE_BITS-1:0]  max_size_ff, max_size_in;
   logic [CNT_BITS-1:0]                 count_ff, count_in;

   // response register
   logic                                strobe_ff;
   logic [tomq_pkg::STATUS_BITS-1:0]    status_ff, status_in;
   logic [tomq_pkg::MSG_ID_BITS-1:0]    pid_ff, pid_in;
   logic [tomq_pkg::MSG_TIME_BITS-1:0]  ptime_ff, ptime_in;
   logic [tomq_pkg::OCC_BITS-1:0]       occ_ff;

   logic                   accept, is_pop, full, empty;
   tomq_pkg::tomq_cmd_type cmd;
   logic [TIME_BITS-1:0]   new_time;
   logic [ID_BITS-1:0]     new_id;

   // chain wiring, one element per cell
   logic [DEPTH-1:0]     cell_valid, cell_le;
   logic [TIME_BITS-1:0] cell_time [DEPTH];
   logic [ID_BITS-1:0]   cell_id   [DEPTH];

   assign accept   = start && !busy_ff;
   assign is_pop   = (req_operation == tomq_pkg::OP_POP);
   assign new_time = TIME_BITS'(req_deliver_time);
   assign new_id   = ID_BITS'(req_message_id);

   // full at DEPTH or at the configured limit, whichever is lower
   assign full  = (count_ff == CNT_BITS'(DEPTH)) ||
                  (CMP_BITS'(count_ff) >= CMP_BITS'(max_size_ff));
   assign empty = !cell_valid[0];

   assign cmd.push = accept && !is_pop && !full;
   assign cmd.pop  = accept && is_pop && !empty;

   // ---------------------------------------------------------------------
   // Sorted chain: slot 0 holds the head. Cell 0 sees a virtual left
   // neighbour that is always ahead, so a new head lands there.
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic                 lv, lle, rv;
      logic [TIME_BITS-1:0] lt, rt;
      logic [ID_BITS-1:0]   lid, rid;

      if (g == 0) begin : g_head
         assign lv  = 1'b1;
         assign lle = 1'b1;
         assign lt  = '0;
         assign lid = '0;
      end else begin : g_body
         assign lv  = cell_valid[g-1];
         assign lle = cell_le[g-1];
         assign lt  = cell_time[g-1];
         assign lid = cell_id[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign rv  = 1'b0;
         assign rt  = '0;
         assign rid = '0;
      end else begin : g_mid
         assign rv  = cell_valid[g+1];
         assign rt  = cell_time[g+1];
         assign rid = cell_id[g+1];
      end

      tomq_cell #(
         .TIME_BITS (TIME_BITS),
         .ID_BITS   (ID_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_time    (new_time),
         .new_id      (new_id),
         .left_valid  (lv),
         .left_le     (lle),
         .left_time   (lt),
         .left_id     (lid),
         .right_valid (rv),
         .right_time  (rt),
         .right_id    (rid),
         .valid       (cell_valid[g]),
         .le          (cell_le[g]),
         .slot_time   (cell_time[g]),
         .slot_id     (cell_id[g])
      );
   end

   // occupancy and response contents
   always_comb begin
      count_in  = count_ff;
      status_in = tomq_pkg::STATUS_DONE;
      pid_in    = '0;
      ptime_in  = '0;
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
         pid_in   = tomq_pkg::MSG_ID_BITS'(cell_id[0]);
         ptime_in = tomq_pkg::MSG_TIME_BITS'(cell_time[0]);
      end else if (is_pop) begin
         status_in = tomq_pkg::STATUS_EMPTY;
      end else begin
         status_in = tomq_pkg::STATUS_FULL;
      end
   end

   assign max_size_in = (csr_valid && csr_ready) ? csr_max_size : max_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         max_size_ff <= tomq_pkg::MAX_SIZE_RESET;
         count_ff    <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         busy_ff     <= 1'b0;
         max_size_ff <= max_size_in;
         count_ff    <= count_in;
         strobe_ff   <= accept;
      end
   end

   // payload of the response; only sampled under the strobe
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         pid_ff    <= pid_in;
         ptime_ff  <= ptime_in;
         occ_ff    <= tomq_pkg::OCC_BITS'(count_in);
      end
   end

   assign busy            = busy_ff;
   assign csr_ready       = !busy_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_popped_id   = pid_ff;
   assign rsp_popped_time = ptime_ff;
   assign rsp_occupancy   = occ_ff;

`ifndef ASSERT_OFF
   // every accepted command yields a response on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("command without response");

   // number of valid cells equals the occupancy count, which stays within DEPTH
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      ($countones(cell_valid) == count_ff) && (count_ff <= CNT_BITS'(DEPTH)))
      else $error("occupancy count out of step with the chain");

   // head is never later than its successor
   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (cell_valid[0] && cell_valid[1]) |-> (cell_time[0] <= cell_time[1]))
      else $error("head of the chain out of order");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timestamp-ordered message queue unit. Push and
// pop transactions go in as bursts with random gaps. An ordered copy of the
// store predicts every response. Each response is then compared, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT   = 1000;

   // port widths, taken from the package
   localparam int OP_W     = tomq_pkg::OP_BITS;
   localparam int ID_W     = tomq_pkg::MSG_ID_BITS;
   localparam int TIME_W   = tomq_pkg::MSG_TIME_BITS;
   localparam int STATUS_W = tomq_pkg::STATUS_BITS;
   localparam int OCC_W    = tomq_pkg::OCC_BITS;
   localparam int CAP_W    = tomq_pkg::MAX_SIZE_BITS;

   // one held message, as the predictor keeps it
   typedef struct {
      logic [TIME_W-1:0] stamp;
      logic [ID_W-1:0]   handle;
   } held_msg_type;

   // one response, as the unit should present it
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     popped_id;
      logic [TIME_W-1:0]   popped_time;
      logic [OCC_W-1:0]    occupancy;
   } queue_result_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_operation    = tomq_pkg::OP_PUSH;
   logic [ID_W-1:0]     req_message_id   = '0;
   logic [TIME_W-1:0]   req_deliver_time = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_popped_id;
   logic [TIME_W-1:0]   rsp_popped_time;
   logic [OCC_W-1:0]    rsp_occupancy;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [CAP_W-1:0]    csr_max_size     = tomq_pkg::MAX_SIZE_RESET;

   timestamp_ordered_message_queue_unit uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_message_id   (req_message_id),
      .req_deliver_time (req_deliver_time),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_popped_id    (rsp_popped_id),
      .rsp_popped_time  (rsp_popped_time),
      .rsp_occupancy    (rsp_occupancy),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_size     (csr_max_size)
   );

   always #CLOCK_HALF clock = ~clock;

   // Predictor state: the held messages in delivery order (head first) and
   // the capacity register as last written.
   held_msg_type     held_msgs[$];
   int unsigned      capacity_setting = tomq_pkg::MAX_SIZE_RESET;
   // responses predicted but not yet seen, oldest first
   queue_result_type pending_results[$];

   logic [TIME_W-1:0] corner_stamps[4] =
      '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;
   int unsigned checked_count  = 0;
   int unsigned push_stored    = 0;
   int unsigned push_refused   = 0;
   int unsigned pop_served     = 0;
   int unsigned pop_on_empty   = 0;

   // Applies one accepted transaction to the predictor and returns the
   // response it must produce. A push goes after every entry with an equal
   // or earlier stamp, so equal stamps leave in arrival order.
   function automatic queue_result_type predict_queue_step(
      input logic [OP_W-1:0]   op,
      input logic [ID_W-1:0]   handle,
      input logic [TIME_W-1:0] stamp
   );
      queue_result_type res;
      held_msg_type     msg;
      int unsigned      limit;
      int unsigned      pos;
      // capacity above the depth acts as the depth
      limit = (capacity_setting < tomq_pkg::DEPTH_DEF) ?
              capacity_setting : tomq_pkg::DEPTH_DEF;
      res.status      = tomq_pkg::STATUS_DONE;
      res.popped_id   = '0;
      res.popped_time = '0;
      if (op == tomq_pkg::OP_PUSH) begin
         // also covers a capacity of zero, and one lowered under occupancy
         if (held_msgs.size() >= limit) begin
            res.status = tomq_pkg::STATUS_FULL;
            push_refused++;
         end else begin
            pos = 0;
            while (pos < held_msgs.size() && held_msgs[pos].stamp <= stamp)
               pos++;
            msg.stamp  = stamp;
            msg.handle = handle;
            held_msgs.insert(pos, msg);
            push_stored++;
         end
      end else begin
         if (held_msgs.size() == 0) begin
            res.status = tomq_pkg::STATUS_EMPTY;
            pop_on_empty++;
         end else begin
            msg = held_msgs.pop_front();
            res.popped_id   = msg.handle;
            res.popped_time = msg.stamp;
            pop_served++;
         end
      end
      res.occupancy = OCC_W'(held_msgs.size());
      return res;
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%s", msg);
   endtask

   // Holds one command transaction until the unit takes it. Called and left
   // at a falling edge; start stays high so that back-to-back commands need
   // no dead cycle.
   task automatic issue_command(
      input logic [OP_W-1:0]   op,
      input logic [ID_W-1:0]   handle,
      input logic [TIME_W-1:0] stamp
   );
      start            <= 1'b1;
      req_operation    <= op;
      req_message_id   <= handle;
      req_deliver_time <= stamp;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.insert(pending_results.size(),
                             predict_queue_step(op, handle, stamp));
      @(negedge clock);
   endtask

   task automatic push_msg(input logic [ID_W-1:0] handle,
                           input logic [TIME_W-1:0] stamp);
      issue_command(tomq_pkg::OP_PUSH, handle, stamp);
   endtask

   // the payload of a pop is ignored, so fill it with noise
   task automatic pop_msg();
      issue_command(tomq_pkg::OP_POP, ID_W'($urandom), $urandom);
   endtask

   task automatic idle_for(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Stops issuing, waits for every predicted response, then lets the
   // pipeline settle before anything touches the register.
   task automatic wait_until_drained();
      int unsigned waited;
      waited = 0;
      start <= 1'b0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write transaction; only ever called with the unit idle.
   task automatic write_max_size(input logic [CAP_W-1:0] value);
      csr_valid    <= 1'b1;
      csr_max_size <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      capacity_setting = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stamps: one pick in four spread out at random, the rest small ties and extremes
   function automatic logic [TIME_W-1:0] pick_stamp();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return TIME_W'($urandom_range(0, 7));
         2: return corner_stamps[$urandom_range(0, 3)];
         default: return 32'hFFFF_FFF8 | TIME_W'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pick_handle();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      return ID_W'($urandom);
   endfunction

   // Empty pops, extreme values, and three equal stamps that have to come
   // back in arrival order.
   task automatic test_ordering_and_ties();
      pop_msg();
      push_msg(16'hFFFF, 32'hFFFF_FFFF);
      push_msg(16'h0000, 32'h0000_0000);
      push_msg(16'h1234, 32'h8000_0000);
      push_msg(16'hABCD, 32'h8000_0000);
      push_msg(16'h5555, 32'h8000_0000);
      repeat (5) pop_msg();
      pop_msg();
   endtask

   // capacity zero refuses everything; capacity one holds a single entry
   task automatic test_capacity_edges();
      wait_until_drained();
      write_max_size(5'd0);
      push_msg(16'h00F0, 32'h0000_0010);
      pop_msg();
      wait_until_drained();
      write_max_size(5'd1);
      push_msg(16'h0F0F, 32'h0000_0020);
      push_msg(16'hF0F0, 32'h0000_0001);
      pop_msg();
   endtask

   // With the capacity above the depth, the depth is the limit. The capacity
   // is then dropped under the occupancy: pushes are refused, pops drain.
   task automatic test_depth_overflow();
      wait_until_drained();
      write_max_size(5'd31);
      repeat (tomq_pkg::DEPTH_DEF) push_msg(pick_handle(), pick_stamp());
      push_msg(pick_handle(), pick_stamp());
      wait_until_drained();
      write_max_size(5'd3);
      push_msg(pick_handle(), pick_stamp());
      pop_msg();
      pop_msg();
      push_msg(pick_handle(), pick_stamp());
   endtask

   // Random traffic across several capacity settings. The mix of pushes and
   // pops shifts from segment to segment so that the store fills to its
   // limit and empties out again; the sender issues in bursts with gaps.
   task automatic test_random_traffic(input int unsigned item_target);
      int unsigned phase_caps[8] = '{16, 5, 1, 17, 0, 12, 2, 16};
      int unsigned per_phase;
      int unsigned burst_left;
      int unsigned segment_left;
      int unsigned push_pct;
      per_phase    = item_target / 8;
      burst_left   = 0;
      segment_left = 0;
      push_pct     = 50;
      foreach (phase_caps[p]) begin
         wait_until_drained();
         write_max_size(CAP_W'(phase_caps[p]));
         repeat (per_phase) begin
            if (segment_left == 0) begin
               segment_left = $urandom_range(8, 40);
               case ($urandom_range(0, 2))
                  0: push_pct = 15;
                  1: push_pct = 50;
                  default: push_pct = 85;
               endcase
            end
            segment_left--;
            // a quarter of bursts run straight on, giving gap-free stretches
            if (burst_left == 0) begin
               if ($urandom_range(0, 3) != 0)
                  idle_for($urandom_range(1, 5));
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            if ($urandom_range(0, 99) < push_pct)
               push_msg(pick_handle(), pick_stamp());
            else
               pop_msg();
         end
      end
   endtask

   // Response checker: every strobe must match the oldest prediction.
   always @(posedge clock) begin : response_check
      queue_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf(
               "response with nothing expected: status %0d id %h time %h occ %0d",
               rsp_status, rsp_popped_id, rsp_popped_time, rsp_occupancy));
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (rsp_status !== want.status || rsp_popped_id !== want.popped_id ||
                rsp_popped_time !== want.popped_time ||
                rsp_occupancy !== want.occupancy) begin
               note_failure($sformatf(
                  {"response %0d mismatch: expected status %0d id %h time %h occ %0d,",
                   " got status %0d id %h time %h occ %0d"},
                  checked_count, want.status, want.popped_id, want.popped_time,
                  want.occupancy, rsp_status, rsp_popped_id, rsp_popped_time,
                  rsp_occupancy));
            end
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      test_ordering_and_ties();
      test_capacity_edges();
      test_depth_overflow();
      test_random_traffic(760);
      wait_until_drained();
      if (pending_results.size() != 0)
         note_failure($sformatf("%0d responses never arrived", pending_results.size()));
      $display("run covered %0d responses: %0d pushes stored, %0d refused as full,",
               checked_count, push_stored, push_refused);
      $display("%0d pops served, %0d pops on an empty queue; %0d mismatches",
               pop_served, pop_on_empty, mismatch_count);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: timestamp_ordered_message_queue_unit.f
hw/rtl/tomq_pkg.sv
hw/rtl/tomq_cell.sv
hw/rtl/timestamp_ordered_message_queue_unit.sv
bench/testbench.sv
